[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/egga_pkg.sv]
// ----------------------------------------------------------------------------
// egga_pkg
// Types and constants for the embedding gather / gradient accumulate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package egga_pkg;

    localparam int VOCAB_DEPTH = 256;
    localparam int MAX_DIM     = 16;
    localparam int STORE_DEPTH = VOCAB_DEPTH * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int TOK_W  = 8;
    localparam int DIX_W  = 4;
    localparam int ELEM_W = 16;
    localparam int GRAD_W = 32;

    localparam int VOCAB_CFG_W = 9;
    localparam int DIM_CFG_W   = 5;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int VOCAB_RESET = 256;
    localparam int DIM_RESET   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIM   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_ACCUM  = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOK_RANGE = 2'd1,
        ST_DIM_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOOK
    } t_state;

    typedef struct packed {
        t_opcode                  opcode;
        logic [TOK_W-1:0]         token_id;
        logic [DIX_W-1:0]         dim_index;
        logic signed [ELEM_W-1:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic signed [GRAD_W-1:0] result_value;
        logic [DIX_W-1:0]         result_dim;
        t_status                  status;
        logic                     last;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/egga_ram.sv]
// ----------------------------------------------------------------------------
// egga_ram
// Simple dual-port ram: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module egga_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/embedding_gather_grad_accumulate.sv]
// ----------------------------------------------------------------------------
// embedding_gather_grad_accumulate
// Embedding table engine: weight loads, row lookups, saturating gradient
// accumulation and gradient reads over two on-chip stores.
// ----------------------------------------------------------------------------
// After reset the gradient store is cleared one entry per cycle over all
// VOCAB_DEPTH * MAX_DIM = 4096 entries; no item is taken during that pass,
// configuration writes are. A load, accumulate or read item, and any item that
// fails its range check, is accepted with any store read issued, then completed
// on the registered read data (and written back for accumulate). A good
// lookup streams one row element per cycle unless the result channel stalls,
// paced by the single read port of the weight store. One output register sits
// between the engine and the result channel, so a new item can be taken while
// a result waits; a stalled result channel stalls the engine.
`default_nettype none

`include "assert_macros.svh"

module embedding_gather_grad_accumulate (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire egga_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output egga_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [egga_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [egga_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import egga_pkg::*;

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [VOCAB_CFG_W-1:0] r_vocab_in_use;
    logic [DIM_CFG_W-1:0]   r_dim_in_use;
    t_in_item               r_item;
    logic [ADDR_W-1:0]      r_base;
    t_status                r_err;
    logic [DIM_CFG_W-1:0]   r_dcnt, n_dcnt;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;

    logic                   in_xfer;
    logic                   out_free;
    logic                   produce;
    logic [DIM_CFG_W-1:0]   dim_lim;
    logic                   tok_bad;
    logic                   dix_bad;
    t_status                in_err;
    logic [ADDR_W-1:0]      in_base;
    logic [ADDR_W-1:0]      in_addr;
    logic [ADDR_W-1:0]      item_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [DIM_CFG_W-1:0]   rd_d;
    logic                   look_last;

    logic                   w_we, w_re;
    logic [ELEM_W-1:0]      w_rdata;
    logic [GRAD_W-1:0]      w_sext;
    logic                   g_we, g_re;
    logic [ADDR_W-1:0]      g_waddr;
    logic [GRAD_W-1:0]      g_wdata;
    logic [GRAD_W-1:0]      g_rdata;
    logic [GRAD_W:0]        acc_sum;
    logic [GRAD_W-1:0]      acc_sat;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // range checks on the incoming item, token first
    assign dim_lim = (32'(r_dim_in_use) > 32'(MAX_DIM)) ? DIM_CFG_W'(MAX_DIM) : r_dim_in_use;
    assign tok_bad = (VOCAB_CFG_W'(i_in_data.token_id) >= r_vocab_in_use)
                  || (32'(i_in_data.token_id) >= 32'(VOCAB_DEPTH));
    assign dix_bad = (DIM_CFG_W'(i_in_data.dim_index) >= dim_lim);

    always_comb begin
        priority if (tok_bad) begin
            in_err = ST_TOK_RANGE;
        end else if ((i_in_data.opcode == OP_LOOKUP) ? (dim_lim == '0) : dix_bad) begin
            in_err = ST_DIM_RANGE;
        end else begin
            in_err = ST_OK;
        end
    end

    assign in_base   = ADDR_W'(i_in_data.token_id) * ADDR_W'(MAX_DIM);
    assign in_addr   = (i_in_data.opcode == OP_LOOKUP)
                     ? in_base : in_base + ADDR_W'(i_in_data.dim_index);
    assign item_addr = r_base + ADDR_W'(r_item.dim_index);
    assign rd_addr   = (r_state == S_IDLE) ? in_addr : r_base + ADDR_W'(rd_d);
    assign look_last = (r_dcnt == dim_lim - DIM_CFG_W'(1));

    assign w_sext = {{(GRAD_W - ELEM_W){w_rdata[ELEM_W-1]}}, w_rdata};

    // saturating gradient add
    assign acc_sum = {g_rdata[GRAD_W-1], g_rdata}
                   + {{(GRAD_W + 1 - ELEM_W){r_item.elem_value[ELEM_W-1]}}, r_item.elem_value};
    always_comb begin
        if (acc_sum[GRAD_W] != acc_sum[GRAD_W-1]) begin
            acc_sat = acc_sum[GRAD_W] ? {1'b1, {(GRAD_W - 1){1'b0}}}
                                      : {1'b0, {(GRAD_W - 1){1'b1}}};
        end else begin
            acc_sat = acc_sum[GRAD_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    if (r_err == ST_OK && r_item.opcode == OP_LOOKUP
                        && dim_lim != DIM_CFG_W'(1)) begin
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LOOK: begin
                if (out_free && look_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath and store controls
    always_comb begin
        produce = 1'b0;
        n_out   = r_out;
        n_dcnt  = r_dcnt;
        w_we    = 1'b0;
        w_re    = 1'b0;
        g_we    = 1'b0;
        g_re    = 1'b0;
        g_waddr = item_addr;
        g_wdata = acc_sat;
        rd_d    = '0;
        unique case (r_state)
            S_CLEAR: begin
                g_we    = 1'b1;
                g_waddr = r_clr_addr;
                g_wdata = '0;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    w_re = (i_in_data.opcode == OP_LOOKUP);
                    g_re = (i_in_data.opcode == OP_ACCUM) || (i_in_data.opcode == OP_READ);
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    produce            = 1'b1;
                    n_out.result_value = '0;
                    n_out.result_dim   = r_item.dim_index;
                    n_out.status       = r_err;
                    n_out.last         = 1'b1;
                    if (r_err != ST_OK) begin
                        if (r_item.opcode == OP_LOOKUP) begin
                            n_out.result_dim = '0;
                        end
                    end else begin
                        unique case (r_item.opcode)
                            OP_LOAD:  w_we = 1'b1;
                            OP_ACCUM: g_we = 1'b1;
                            OP_READ:  n_out.result_value = g_rdata;
                            OP_LOOKUP: begin
                                n_out.result_value = w_sext;
                                n_out.result_dim   = '0;
                                n_out.last         = (dim_lim == DIM_CFG_W'(1));
                                if (dim_lim != DIM_CFG_W'(1)) begin
                                    w_re   = 1'b1;
                                    rd_d   = DIM_CFG_W'(1);
                                    n_dcnt = DIM_CFG_W'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_LOOK: begin
                if (out_free) begin
                    produce            = 1'b1;
                    n_out.result_value = w_sext;
                    n_out.result_dim   = r_dcnt[DIX_W-1:0];
                    n_out.status       = ST_OK;
                    n_out.last         = look_last;
                    if (!look_last) begin
                        w_re   = 1'b1;
                        rd_d   = r_dcnt + DIM_CFG_W'(1);
                        n_dcnt = r_dcnt + DIM_CFG_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
            r_vocab_in_use <= VOCAB_CFG_W'(VOCAB_RESET);
            r_dim_in_use   <= DIM_CFG_W'(DIM_RESET);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VOCAB: r_vocab_in_use <= i_cfg_wdata[VOCAB_CFG_W-1:0];
                    CFG_DIM:   r_dim_in_use   <= i_cfg_wdata[DIM_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
            r_base <= in_base;
            r_err  <= in_err;
        end
        r_dcnt <= n_dcnt;
        r_out  <= n_out;
    end

    egga_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (item_addr),
        .i_wdata (r_item.elem_value),
        .i_re    (w_re),
        .i_raddr (rd_addr),
        .o_rdata (w_rdata)
    );

    egga_ram #(
        .WIDTH (GRAD_W),
        .DEPTH (STORE_DEPTH)
    ) u_grad_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (g_re),
        .i_raddr (rd_addr),
        .o_rdata (g_rdata)
    );

    `ASSERT_ALWAYS(a_no_rmw_overlap, !(g_we && g_re && (g_waddr == rd_addr)), "gradient read and write overlap on one entry")
    `ASSERT_ALWAYS(a_produce_room, !produce || !r_out_valid || i_out_ready, "result produced into a full output register")
    `ASSERT_ALWAYS(a_look_in_row, (r_state != S_LOOK) || (r_dcnt < dim_lim), "lookup element index beyond the row")
    `ASSERT_ALWAYS(a_err_no_write, !((r_state == S_EXEC) && (r_err != ST_OK)) || (!w_we && !g_we), "failed item writes a store")
    `ASSERT_NEXT(a_last_to_idle, produce && n_out.last, r_state == S_IDLE, "engine busy after the last result of an item")

endmodule

`default_nettype wire
